// ===== rtl/core/coefficient_quantizer_top_defines.svh =====
// assertion macros for the coefficient quantizer
// used by coefficient_quantizer_top; expects i_clk and i_rst_n in scope
`ifndef COEFFICIENT_QUANTIZER_TOP_DEFINES_SVH
`define COEFFICIENT_QUANTIZER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("coefficient quantizer check failed");

// next-cycle implication, disabled during reset
`define CQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("coefficient quantizer check failed");

`endif

// ===== rtl/core/cq_pkg.sv =====
// shared widths, config register codes and types for the coefficient quantizer
// no dependencies
package cq_pkg;

    localparam int COEF_W   = 16;
    localparam int SCALE_W  = 20;
    localparam int PROD_W   = COEF_W + SCALE_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int SHIFT_W  = 5;
    localparam int RO_W     = 30;
    localparam int LMAG_W   = ACC_W - 8;
    localparam int REM_W    = 31;
    localparam int ADAPT_W  = 31;
    localparam int RES_W    = 10;
    localparam int MSUM_W   = 32;
    localparam int DIFF_W   = REM_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RO_W;

    localparam logic [SHIFT_W-1:0] RESIDUE_BASE  = SHIFT_W'(8);
    localparam logic [LMAG_W-1:0]  LEVEL_MIN_MAG = LMAG_W'(32768);
    localparam logic [LMAG_W-1:0]  LEVEL_MAX_MAG = LMAG_W'(32767);
    localparam logic [ADAPT_W-1:0] ADAPT_MAX     = {ADAPT_W{1'b1}};
    localparam logic signed [DIFF_W-1:0] RES_MAX = DIFF_W'(255);
    localparam logic signed [DIFF_W-1:0] RES_MIN = -DIFF_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANT_SHIFT     = 2'd0,
        CFG_ROUND_OFFSET    = 2'd1,
        CFG_ADAPTIVE_ENABLE = 2'd2,
        CFG_ADAPTIVE_SHIFT  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SHIFT_W-1:0] quant_shift;
        logic [RO_W-1:0]    round_offset;
        logic               adaptive_enable;
        logic [SHIFT_W-1:0] adaptive_shift;
    } t_cfg;

    // level shift never goes below the residue base
    function automatic logic [SHIFT_W-1:0] f_eff_shift(input logic [SHIFT_W-1:0] qs);
        return (qs < RESIDUE_BASE) ? RESIDUE_BASE : qs;
    endfunction

endpackage

// ===== rtl/core/cq_round_unit.sv =====
// rounding and shift unit: level magnitude, low remainder and adaptive level
// from the exact product; depends on cq_pkg
module cq_round_unit (
    input  logic [cq_pkg::PROD_W-1:0]  i_prod,
    input  cq_pkg::t_cfg               i_cfg,
    output logic [cq_pkg::LMAG_W-1:0]  o_lmag,
    output logic [cq_pkg::REM_W-1:0]   o_rem,
    output logic [cq_pkg::ADAPT_W-1:0] o_adapt
);

    logic [cq_pkg::SHIFT_W-1:0] w_qs;
    logic [cq_pkg::ACC_W-1:0]   w_acc;
    logic [cq_pkg::ACC_W-1:0]   w_mask;
    logic [cq_pkg::ACC_W-1:0]   w_lvl_sh;
    logic [cq_pkg::ACC_W-1:0]   w_rem_full;
    logic [cq_pkg::ACC_W-1:0]   w_half;
    logic [cq_pkg::ACC_W-1:0]   w_aacc;
    logic [cq_pkg::ACC_W-1:0]   w_ash;

    always_comb begin
        w_qs       = cq_pkg::f_eff_shift(i_cfg.quant_shift);
        w_acc      = {1'b0, i_prod} + cq_pkg::ACC_W'(i_cfg.round_offset);
        w_lvl_sh   = w_acc >> w_qs;
        w_mask     = (cq_pkg::ACC_W'(1) << w_qs) - cq_pkg::ACC_W'(1);
        w_rem_full = w_acc & w_mask;
        o_lmag     = w_lvl_sh[cq_pkg::LMAG_W-1:0];
        o_rem      = w_rem_full[cq_pkg::REM_W-1:0];

        // adaptive level rounds at half of its own shift; a zero shift adds nothing
        if (i_cfg.adaptive_shift == '0) begin
            w_half = '0;
        end else begin
            w_half = cq_pkg::ACC_W'(1) << (i_cfg.adaptive_shift - cq_pkg::SHIFT_W'(1));
        end
        w_aacc = {1'b0, i_prod} + w_half;
        w_ash  = w_aacc >> i_cfg.adaptive_shift;
        if (!i_cfg.adaptive_enable) begin
            o_adapt = '0;
        end else if (|w_ash[cq_pkg::ACC_W-1:cq_pkg::ADAPT_W]) begin
            o_adapt = cq_pkg::ADAPT_MAX;
        end else begin
            o_adapt = w_ash[cq_pkg::ADAPT_W-1:0];
        end
    end

endmodule

// ===== rtl/core/coefficient_quantizer_top.sv =====
// coefficient quantizer top level: config registers, four-stage pipeline, block sum
// depends on cq_pkg, cq_round_unit and coefficient_quantizer_top_defines.svh
//
// Forward quantizer taking one coefficient and its scale per item and giving one
// result per item in order. Sustained rate is one item per cycle while i_out_stall is
// low. It has four registers: input register, product register (16x20 multiply),
// rounding register (add and shift) and result register (residue, clip and block
// sum); o_out_valid marks an item in the result register. Each stage fills its own
// bubble, so items are still taken while a finished result waits under i_out_stall
// until every stage is full. Write config through i_cfg_we / i_cfg_index /
// i_cfg_data only while the pipeline is empty; the block does not enforce it.
// magnitude_sum restarts after an item flagged last_in_block. No clearing pass after reset.
`include "coefficient_quantizer_top_defines.svh"

module coefficient_quantizer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [cq_pkg::COEF_W-1:0] i_coefficient,
    input  logic [cq_pkg::SCALE_W-1:0]       i_scale,
    input  logic                             i_last_in_block,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [cq_pkg::COEF_W-1:0] o_level,
    output logic signed [cq_pkg::RES_W-1:0]  o_rounding_residue,
    output logic [cq_pkg::ADAPT_W-1:0]       o_adaptive_level,
    output logic [cq_pkg::MSUM_W-1:0]        o_magnitude_sum,
    output logic                             o_last_out,
    input  logic                             i_cfg_we,
    input  logic [cq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    cq_pkg::t_cfg r_cfg;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 1
    logic [cq_pkg::COEF_W-1:0]  r_coef1;
    logic [cq_pkg::SCALE_W-1:0] r_scale1;
    logic                       r_last1;
    // stage 2
    logic [cq_pkg::PROD_W-1:0]  r_prod2;
    logic                       r_neg2, r_last2;
    // stage 3
    logic [cq_pkg::LMAG_W-1:0]  r_lmag3;
    logic [cq_pkg::REM_W-1:0]   r_rem3;
    logic [cq_pkg::ADAPT_W-1:0] r_adapt3;
    logic                       r_neg3, r_last3;
    // stage 4
    logic                       r_neg4;
    logic [cq_pkg::MSUM_W-1:0]  r_block_sum;
    logic [cq_pkg::MSUM_W-1:0]  n_block_sum;

    logic                       w_neg1;
    logic [cq_pkg::COEF_W-1:0]  w_mag1;
    logic [cq_pkg::PROD_W-1:0]  w_prod1;
    logic [cq_pkg::LMAG_W-1:0]  w_lmag2;
    logic [cq_pkg::REM_W-1:0]   w_rem2;
    logic [cq_pkg::ADAPT_W-1:0] w_adapt2;

    logic [cq_pkg::SHIFT_W-1:0]       w_qs3;
    logic signed [cq_pkg::DIFF_W-1:0] w_diff3;
    logic signed [cq_pkg::DIFF_W-1:0] w_diff_sh3;
    logic [cq_pkg::RES_W-1:0]         w_res3;
    logic [cq_pkg::LMAG_W-1:0]        w_clip3;
    logic [cq_pkg::COEF_W-1:0]        w_level3;
    logic [cq_pkg::MSUM_W-1:0]        w_sum3;

    // each stage loads when empty or when the stage after it moves on
    assign w_rdy4     = !r_v4 || !i_out_stall;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quant_shift     <= cq_pkg::SHIFT_W'(14);
            r_cfg.round_offset    <= '0;
            r_cfg.adaptive_enable <= 1'b0;
            r_cfg.adaptive_shift  <= cq_pkg::SHIFT_W'(14);
        end else if (i_cfg_we) begin
            case (cq_pkg::t_cfg_index'(i_cfg_index))
                cq_pkg::CFG_QUANT_SHIFT: begin
                    r_cfg.quant_shift <= i_cfg_data[cq_pkg::SHIFT_W-1:0];
                end
                cq_pkg::CFG_ROUND_OFFSET: begin
                    r_cfg.round_offset <= i_cfg_data[cq_pkg::RO_W-1:0];
                end
                cq_pkg::CFG_ADAPTIVE_ENABLE: begin
                    r_cfg.adaptive_enable <= i_cfg_data[0];
                end
                cq_pkg::CFG_ADAPTIVE_SHIFT: begin
                    r_cfg.adaptive_shift <= i_cfg_data[cq_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_block_sum <= '0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy4 && r_v3) begin
                r_block_sum <= n_block_sum;
            end
        end
    end

    // stage 1 -> 2: magnitude and exact product
    always_comb begin
        w_neg1  = r_coef1[cq_pkg::COEF_W-1];
        w_mag1  = w_neg1 ? (~r_coef1 + cq_pkg::COEF_W'(1)) : r_coef1;
        w_prod1 = cq_pkg::PROD_W'(w_mag1) * cq_pkg::PROD_W'(r_scale1);
    end

    cq_round_unit u_round (
        .i_prod  (r_prod2),
        .i_cfg   (r_cfg),
        .o_lmag  (w_lmag2),
        .o_rem   (w_rem2),
        .o_adapt (w_adapt2)
    );

    // stage 3 -> 4: residue, clip, block sum
    always_comb begin
        w_qs3      = cq_pkg::f_eff_shift(r_cfg.quant_shift);
        w_diff3    = $signed({2'b00, r_rem3}) - $signed({3'b000, r_cfg.round_offset});
        w_diff_sh3 = w_diff3 >>> (w_qs3 - cq_pkg::RESIDUE_BASE);
        if (w_diff_sh3 > cq_pkg::RES_MAX) begin
            w_res3 = cq_pkg::RES_MAX[cq_pkg::RES_W-1:0];
        end else if (w_diff_sh3 < cq_pkg::RES_MIN) begin
            w_res3 = cq_pkg::RES_MIN[cq_pkg::RES_W-1:0];
        end else begin
            w_res3 = w_diff_sh3[cq_pkg::RES_W-1:0];
        end

        if (r_neg3) begin
            w_clip3  = (r_lmag3 > cq_pkg::LEVEL_MIN_MAG) ? cq_pkg::LEVEL_MIN_MAG : r_lmag3;
            w_level3 = ~w_clip3[cq_pkg::COEF_W-1:0] + cq_pkg::COEF_W'(1);
        end else begin
            w_clip3  = (r_lmag3 > cq_pkg::LEVEL_MAX_MAG) ? cq_pkg::LEVEL_MAX_MAG : r_lmag3;
            w_level3 = w_clip3[cq_pkg::COEF_W-1:0];
        end

        // sum uses the unclipped magnitude
        w_sum3      = r_block_sum + cq_pkg::MSUM_W'(r_lmag3);
        n_block_sum = r_last3 ? '0 : w_sum3;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in_valid) begin
            r_coef1  <= i_coefficient;
            r_scale1 <= i_scale;
            r_last1  <= i_last_in_block;
        end
        if (w_rdy2 && r_v1) begin
            r_prod2 <= w_prod1;
            r_neg2  <= w_neg1;
            r_last2 <= r_last1;
        end
        if (w_rdy3 && r_v2) begin
            r_lmag3  <= w_lmag2;
            r_rem3   <= w_rem2;
            r_adapt3 <= w_adapt2;
            r_neg3   <= r_neg2;
            r_last3  <= r_last2;
        end
        if (w_rdy4 && r_v3) begin
            o_level            <= w_level3;
            o_rounding_residue <= w_res3;
            o_adaptive_level   <= r_adapt3;
            o_magnitude_sum    <= w_sum3;
            o_last_out         <= r_last3;
            r_neg4             <= r_neg3;
        end
    end

    `CQ_ASSERT_NEXT(a_sum_restarts, w_rdy4 && r_v3 && r_last3, r_block_sum == '0)
    `CQ_ASSERT_NEXT(a_sum_carries, w_rdy4 && r_v3 && !r_last3, r_block_sum == o_magnitude_sum)
    `CQ_ASSERT_IMPL(a_level_sign, o_out_valid && (o_level != '0), o_level[cq_pkg::COEF_W-1] == r_neg4)
    `CQ_ASSERT_IMPL(a_adapt_off, o_out_valid && !r_cfg.adaptive_enable, o_adaptive_level == '0)

endmodule

// ===== verif/cq_quant_scoreboard_pkg.sv =====
// scoreboard for the coefficient quantizer testbench: level, residue, adaptive level
// and block sum prediction plus in-order result checking; depends on cq_pkg
package cq_quant_scoreboard_pkg;
    import cq_pkg::*;

    typedef struct {
        logic signed [COEF_W-1:0] level;
        logic signed [RES_W-1:0]  residue;
        logic [ADAPT_W-1:0]       adaptive;
        logic [MSUM_W-1:0]        msum;
        logic                     last;
    } t_quant_result;

    class t_quant_scoreboard;
        logic [SHIFT_W-1:0] level_shift;
        logic [RO_W-1:0]    round_ofs;
        logic               adapt_on;
        logic [SHIFT_W-1:0] adapt_shift;
        logic [MSUM_W-1:0]  block_sum;
        t_quant_result      quant_q[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        blocks;

        function new();
            level_shift = SHIFT_W'(14);
            round_ofs   = '0;
            adapt_on    = 1'b0;
            adapt_shift = SHIFT_W'(14);
            block_sum   = '0;
            mismatches  = 0;
            checked     = 0;
            blocks      = 0;
        endfunction

        function void write_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_QUANT_SHIFT:     level_shift = data[SHIFT_W-1:0];
                CFG_ROUND_OFFSET:    round_ofs   = data[RO_W-1:0];
                CFG_ADAPTIVE_ENABLE: adapt_on    = data[0];
                CFG_ADAPTIVE_SHIFT:  adapt_shift = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_coefficient(logic signed [COEF_W-1:0] coef,
                                       logic [SCALE_W-1:0] scl, logic last);
            logic [COEF_W-1:0] raw;
            logic [COEF_W:0]   mag;
            logic [63:0]       prod;
            logic [63:0]       lmag;
            logic [63:0]       back;
            logic [63:0]       clipped;
            logic [63:0]       adapt;
            logic [63:0]       half;
            int unsigned       qs;
            int unsigned       rs;
            longint            res;
            t_quant_result     r;

            raw  = coef;
            mag  = raw[COEF_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
            prod = 64'(mag) * 64'(scl);
            // level shift never drops below the residue base
            qs   = (level_shift < RESIDUE_BASE) ? RESIDUE_BASE : level_shift;
            rs   = qs - RESIDUE_BASE;
            lmag = (prod + 64'(round_ofs)) >> qs;
            back = lmag << qs;

            // residue shift rounds toward minus infinity
            if (prod >= back)
                res = longint'((prod - back) >> rs);
            else
                res = -longint'((back - prod + (64'd1 << rs) - 64'd1) >> rs);
            if (res < -256) res = -256;
            if (res > 255)  res = 255;
            r.residue = RES_W'(res);

            if (raw[COEF_W-1]) begin
                clipped = (lmag > 64'(LEVEL_MIN_MAG)) ? 64'(LEVEL_MIN_MAG) : lmag;
                r.level = COEF_W'(64'd0 - clipped);
            end else begin
                clipped = (lmag > 64'(LEVEL_MAX_MAG)) ? 64'(LEVEL_MAX_MAG) : lmag;
                r.level = COEF_W'(clipped);
            end

            adapt = '0;
            if (adapt_on) begin
                half  = (adapt_shift == 0) ? 64'd0 : (64'd1 << (adapt_shift - 1));
                adapt = (prod + half) >> adapt_shift;
                if (adapt > 64'(ADAPT_MAX)) adapt = 64'(ADAPT_MAX);
            end
            r.adaptive = ADAPT_W'(adapt);

            // sum takes the unclipped magnitude
            r.msum    = block_sum + lmag[MSUM_W-1:0];
            r.last    = last;
            block_sum = last ? '0 : r.msum;
            if (last) blocks++;
            quant_q.push_back(r);
        endfunction

        function void check_result(t_quant_result got);
            t_quant_result want;

            if (quant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: level %0d sum %0d", got.level, got.msum);
                return;
            end
            want = quant_q.pop_front();
            checked++;
            if (got.level !== want.level || got.residue !== want.residue ||
                got.adaptive !== want.adaptive || got.msum !== want.msum ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch (expected/actual): level %0d/%0d residue %0d/%0d",
                             checked, want.level, got.level, want.residue, got.residue);
                    $display("  adaptive %0d/%0d sum %0d/%0d last %0b/%0b",
                             want.adaptive, got.adaptive, want.msum, got.msum,
                             want.last, got.last);
                end
            end
        endfunction

        function int unsigned outstanding();
            return quant_q.size();
        endfunction
    endclass

endpackage

// ===== verif/tb_coefficient_quantizer_top.sv =====
// self-checking testbench for coefficient_quantizer_top: directed extremes, then
// random blocks under changing register settings with random idling on both sides
// depends on cq_pkg, cq_quant_scoreboard_pkg and the quantizer rtl
module tb_coefficient_quantizer_top;
    import cq_pkg::*;
    import cq_quant_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int DIRECTED_N      = 9;

    localparam int DIR_COEF [DIRECTED_N] =
        '{0, 32767, -32768, -32768, -32768, -1, 32767, 1, -12345};
    localparam int DIR_SCALE [DIRECTED_N] =
        '{1048575, 1048575, 1048575, 0, 16384, 1048575, 1, 1, 16384};
    localparam bit DIR_LAST [DIRECTED_N] = '{0, 0, 0, 0, 0, 0, 0, 0, 1};

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [COEF_W-1:0]  i_coefficient;
    logic [SCALE_W-1:0]        i_scale;
    logic                      i_last_in_block;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [COEF_W-1:0]  o_level;
    logic signed [RES_W-1:0]   o_rounding_residue;
    logic [ADAPT_W-1:0]        o_adaptive_level;
    logic [MSUM_W-1:0]         o_magnitude_sum;
    logic                      o_last_out;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    t_quant_scoreboard quant_sb;
    bit                idling_on;
    int unsigned       cycle_count = 0;
    int unsigned       settings_used = 0;

    coefficient_quantizer_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_coefficient      (i_coefficient),
        .i_scale            (i_scale),
        .i_last_in_block    (i_last_in_block),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_level            (o_level),
        .o_rounding_residue (o_rounding_residue),
        .o_adaptive_level   (o_adaptive_level),
        .o_magnitude_sum    (o_magnitude_sum),
        .o_last_out         (o_last_out),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_out_stall <= idling_on && ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge i_clk) begin
        t_quant_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.level    = o_level;
            got.residue  = o_rounding_residue;
            got.adaptive = o_adaptive_level;
            got.msum     = o_magnitude_sum;
            got.last     = o_last_out;
            quant_sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     CYCLE_LIMIT, quant_sb.outstanding());
            $display("TEST FAILED");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic push_coefficient(input logic signed [COEF_W-1:0] coef,
                                    input logic [SCALE_W-1:0] scl, input logic last);
        while (idling_on && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_coefficient   <= coef;
        i_scale         <= scl;
        i_last_in_block <= last;
        do @(posedge i_clk); while (o_in_stall);
        quant_sb.note_coefficient(coef, scl, last);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (quant_sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        quant_sb.write_register(idx, data);
    endtask

    task automatic apply_setting(input logic [SHIFT_W-1:0] qs, input logic [RO_W-1:0] ro,
                                 input logic aen, input logic [SHIFT_W-1:0] as);
        drain_pipeline();
        write_cfg(CFG_QUANT_SHIFT, CFG_DATA_W'(qs));
        write_cfg(CFG_ROUND_OFFSET, CFG_DATA_W'(ro));
        write_cfg(CFG_ADAPTIVE_ENABLE, CFG_DATA_W'(aen));
        write_cfg(CFG_ADAPTIVE_SHIFT, CFG_DATA_W'(as));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coefficient();
        logic signed [COEF_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = COEF_W'($urandom);
            5:             c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            6:             c = COEF_W'($urandom_range(0, 2)) - 16'sd1;
            default: begin
                c = COEF_W'($urandom_range(0, 2047));
                if ($urandom_range(0, 1)) c = -c;
            end
        endcase
        return c;
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SCALE_W'($urandom);
            5:             return SCALE_W'($urandom_range(0, 64));
            6:             return $urandom_range(0, 1) ? '1 : '0;
            default:       return SCALE_W'($urandom_range(1, 32768));
        endcase
    endfunction

    initial begin
        int unsigned        p;
        int unsigned        k;
        int unsigned        eff;
        logic [SHIFT_W-1:0] qs;
        logic [SHIFT_W-1:0] as;
        logic [RO_W-1:0]    ro;
        logic               aen;

        quant_sb        = new();
        idling_on       = 1'b1;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_coefficient   = '0;
        i_scale         = '0;
        i_last_in_block = 1'b0;
        i_out_stall     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_QUANT_SHIFT;
        i_cfg_data      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes under reset values, then shift floor with huge offset and
        // zero adaptive shift, then top level shift with adaptive saturation
        for (p = 0; p < 3; p++) begin
            if (p == 1) apply_setting(SHIFT_W'(0), '1, 1'b1, SHIFT_W'(0));
            if (p == 2) apply_setting(SHIFT_W'(31), RO_W'(30'h2000_0000), 1'b1, SHIFT_W'(1));
            for (k = 0; k < DIRECTED_N; k++)
                push_coefficient(COEF_W'(DIR_COEF[k]), SCALE_W'(DIR_SCALE[k]), DIR_LAST[k]);
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                qs = SHIFT_W'(8); ro = '1; aen = 1'b1; as = SHIFT_W'(30);
            end else if (p == 1) begin
                qs = SHIFT_W'(30); ro = '0; aen = 1'b1; as = SHIFT_W'(1);
            end else begin
                case ($urandom_range(0, 5))
                    0:       qs = SHIFT_W'($urandom_range(0, 7));
                    1:       qs = SHIFT_W'(31);
                    2:       qs = SHIFT_W'(30);
                    3:       qs = SHIFT_W'(8);
                    default: qs = SHIFT_W'($urandom_range(8, 30));
                endcase
                eff = (qs < RESIDUE_BASE) ? RESIDUE_BASE : qs;
                case ($urandom_range(0, 4))
                    0:       ro = '0;
                    1:       ro = RO_W'(64'd1 << (eff - 1));
                    2:       ro = RO_W'($urandom) & RO_W'((64'd1 << eff) - 64'd1);
                    3:       ro = RO_W'($urandom);
                    default: ro = '1;
                endcase
                aen = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 5))
                    0:       as = SHIFT_W'(0);
                    1:       as = SHIFT_W'(31);
                    2:       as = SHIFT_W'(1);
                    default: as = SHIFT_W'($urandom_range(1, 30));
                endcase
            end
            apply_setting(qs, ro, aen, as);
            // two back-to-back phases run with no gaps on either side
            idling_on = !(p == 4 || p == 5);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                push_coefficient(pick_coefficient(), pick_scale(),
                                 $urandom_range(0, 15) == 0);
        end

        idling_on = 1'b1;
        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("quantized %0d coefficients in %0d closed blocks over %0d register settings",
                 quant_sb.checked, quant_sb.blocks, settings_used + 1);
        $display("mismatches %0d, results left waiting %0d",
                 quant_sb.mismatches, quant_sb.outstanding());
        if (quant_sb.mismatches == 0 && quant_sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
